// File: sv/md5_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 package
// Types, microcode program and round tables shared by the MD5 engine.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	localparam logic [3:0] LEN_WORD_LO = 4'd14;
	localparam logic [3:0] LEN_WORD_HI = 4'd15;
	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam logic [5:0] LAST_ROUND  = 6'd63;

	typedef enum logic [2:0] {
		ST_WAIT, ST_PAD, ST_ZERO, ST_LEN_LO, ST_LEN_HI, ST_RUN, ST_FINAL, ST_OUT
	} step_t;

	typedef enum logic [2:0] {
		BUF_NONE, BUF_ABSORB, BUF_PAD, BUF_ZERO, BUF_LEN_LO, BUF_LEN_HI
	} buf_op_t;

	typedef enum logic [1:0] {
		CORE_HOLD, CORE_IV, CORE_ROUND, CORE_ADD
	} core_op_t;

	typedef enum logic [2:0] {
		JMP_ALWAYS, JMP_ABSORB, JMP_PAD, JMP_ZERO, JMP_ROUND, JMP_FINAL, JMP_OUT
	} jmp_t;

	typedef struct packed {
		logic     ready;
		buf_op_t  buf_op;
		core_op_t core_op;
		jmp_t     jmp;
		step_t    target;
	} uword_t;

	typedef struct packed {
		core_op_t   op;
		logic [5:0] rnd;
	} core_ctl_t;

	function automatic uword_t ucode(input step_t step);
		uword_t w;
		case (step)
			ST_WAIT:   w = '{ready: 1'b1, buf_op: BUF_ABSORB, core_op: CORE_HOLD,
			                 jmp: JMP_ABSORB, target: ST_WAIT};
			ST_PAD:    w = '{ready: 1'b0, buf_op: BUF_PAD, core_op: CORE_HOLD,
			                 jmp: JMP_PAD, target: ST_ZERO};
			ST_ZERO:   w = '{ready: 1'b0, buf_op: BUF_ZERO, core_op: CORE_HOLD,
			                 jmp: JMP_ZERO, target: ST_LEN_LO};
			ST_LEN_LO: w = '{ready: 1'b0, buf_op: BUF_LEN_LO, core_op: CORE_HOLD,
			                 jmp: JMP_ALWAYS, target: ST_LEN_HI};
			ST_LEN_HI: w = '{ready: 1'b0, buf_op: BUF_LEN_HI, core_op: CORE_HOLD,
			                 jmp: JMP_ALWAYS, target: ST_RUN};
			ST_RUN:    w = '{ready: 1'b0, buf_op: BUF_NONE, core_op: CORE_ROUND,
			                 jmp: JMP_ROUND, target: ST_FINAL};
			ST_FINAL:  w = '{ready: 1'b0, buf_op: BUF_NONE, core_op: CORE_ADD,
			                 jmp: JMP_FINAL, target: ST_WAIT};
			ST_OUT:    w = '{ready: 1'b0, buf_op: BUF_NONE, core_op: CORE_IV,
			                 jmp: JMP_OUT, target: ST_WAIT};
			default:   w = '{ready: 1'b0, buf_op: BUF_NONE, core_op: CORE_HOLD,
			                 jmp: JMP_ALWAYS, target: ST_WAIT};
		endcase
		return w;
	endfunction

	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] i;
		logic [3:0] g;
		i = rnd[3:0];
		case (rnd[5:4])
			2'd0:    g = i;
			2'd1:    g = 4'(i * 4'd5 + 4'd1);
			2'd2:    g = 4'(i * 4'd3 + 4'd5);
			default: g = 4'(i * 4'd7);
		endcase
		return g;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
		logic [4:0] s;
		case ({rnd[5:4], rnd[1:0]})
			4'd0:    s = 5'd7;
			4'd1:    s = 5'd12;
			4'd2:    s = 5'd17;
			4'd3:    s = 5'd22;
			4'd4:    s = 5'd5;
			4'd5:    s = 5'd9;
			4'd6:    s = 5'd14;
			4'd7:    s = 5'd20;
			4'd8:    s = 5'd4;
			4'd9:    s = 5'd11;
			4'd10:   s = 5'd16;
			4'd11:   s = 5'd23;
			4'd12:   s = 5'd6;
			4'd13:   s = 5'd10;
			4'd14:   s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] sine_k(input logic [5:0] rnd);
		logic [31:0] k;
		case (rnd)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// File: sv/md5_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 round datapath
// Working registers a..d and the chaining value; one MD5 round per cycle.
// ----------------------------------------------------------------------------
module md5_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire md5_pkg::core_ctl_t ctl,
	input  wire logic [31:0]        msg,
	output logic [127:0]            digest
);

	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] dbl;
	logic [31:0] b_new;

	always_comb begin
		case (ctl.rnd[5:4])
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum   = a_q + f + md5_pkg::sine_k(ctl.rnd) + msg;
		dbl   = {sum, sum} << md5_pkg::rot_amt(ctl.rnd);
		b_new = b_q + dbl[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= md5_pkg::IV0;
			chain_q[1] <= md5_pkg::IV1;
			chain_q[2] <= md5_pkg::IV2;
			chain_q[3] <= md5_pkg::IV3;
			a_q        <= md5_pkg::IV0;
			b_q        <= md5_pkg::IV1;
			c_q        <= md5_pkg::IV2;
			d_q        <= md5_pkg::IV3;
		end else begin
			case (ctl.op)
				md5_pkg::CORE_IV: begin
					chain_q[0] <= md5_pkg::IV0;
					chain_q[1] <= md5_pkg::IV1;
					chain_q[2] <= md5_pkg::IV2;
					chain_q[3] <= md5_pkg::IV3;
					a_q        <= md5_pkg::IV0;
					b_q        <= md5_pkg::IV1;
					c_q        <= md5_pkg::IV2;
					d_q        <= md5_pkg::IV3;
				end
				md5_pkg::CORE_ROUND: begin
					a_q <= d_q;
					d_q <= c_q;
					c_q <= b_q;
					b_q <= b_new;
				end
				md5_pkg::CORE_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					a_q        <= chain_q[0] + a_q;
					b_q        <= chain_q[1] + b_q;
					c_q        <= chain_q[2] + c_q;
					d_q        <= chain_q[3] + d_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign digest = {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};

endmodule
`default_nettype wire

// File: sv/md5_message_digest.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 message digest engine
// Streaming MD5 with a microcoded sequencer over a one-round-per-cycle core.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries up to four message bytes per transfer (first byte lowest)
//   with a byte count; tlast ends the message. m_axis carries the 128-bit
//   digest, one transfer per message.
//   A transfer that does not fill the 64-byte block is absorbed directly. A
//   transfer that fills it starts the 64 rounds in the core and the
//   chaining add, and s_axis_tready stays low until they are done.
//   On tlast, the engine writes the pad byte, zero-fills up to the length
//   words, writes the two length words and runs one or two more blocks;
//   the digest is loaded into the output register after the final block.
//   The output register parts the two sides: the next message is taken while
//   a digest waits. If a second digest is ready while the first is still
//   stalled, the sequencer holds until m_axis_tready frees the register.
//   Reset loads the initial vector and clears the length and fill counters;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module md5_message_digest (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [39:0]  s_axis_tdata,  // message_word[31:0], byte_count[34:32]
	input  wire logic         s_axis_tlast,  // last
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [127:0]      m_axis_tdata   // digest_low[63:0], digest_high[127:64]
);

	md5_pkg::step_t     step_q, step_d;
	md5_pkg::uword_t    uw;
	md5_pkg::core_ctl_t core_ctl;

	logic [31:0]  buf_q [16];
	logic [5:0]   fill_q;
	logic [31:0]  acc_q;
	logic [63:0]  bits_q;
	logic [5:0]   rnd_q;
	logic         last_q, pad_q, len_q;
	logic         out_valid_q;
	logic [127:0] out_data_q;
	logic [127:0] digest;

	logic         accept;
	logic         out_free;
	logic         load_out;
	logic [2:0]   n;
	logic [31:0]  wmask, amask;
	logic [31:0]  acc_m;
	logic [4:0]   sh;
	logic [63:0]  merged;
	logic [2:0]   lane_sum;
	logic [6:0]   fill_sum;
	logic [3:0]   word_idx;
	logic         we;
	logic [3:0]   waddr;
	logic [31:0]  wdata;

	assign uw            = md5_pkg::ucode(step_q);
	assign s_axis_tready = uw.ready;
	assign accept        = s_axis_tvalid & uw.ready;
	assign out_free      = ~out_valid_q | m_axis_tready;
	assign load_out      = (uw.jmp == md5_pkg::JMP_OUT) & out_free;
	assign word_idx      = fill_q[5:2];

	always_comb begin
		n = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
		for (int k = 0; k < 4; k++) begin
			wmask[8*k +: 8] = (3'(k) < n) ? 8'hFF : 8'h00;
			amask[8*k +: 8] = (3'(k) < {1'b0, fill_q[1:0]}) ? 8'hFF : 8'h00;
		end
		acc_m    = acc_q & amask;
		sh       = {fill_q[1:0], 3'b000};
		merged   = {32'b0, acc_m} | ({32'b0, s_axis_tdata[31:0] & wmask} << sh);
		lane_sum = {1'b0, fill_q[1:0]} + n;
		fill_sum = {1'b0, fill_q} + {4'b0, n};
	end

	always_comb begin
		we    = 1'b0;
		waddr = word_idx;
		wdata = merged[31:0];
		case (uw.buf_op)
			md5_pkg::BUF_ABSORB: we = accept & lane_sum[2];
			md5_pkg::BUF_PAD: begin
				we    = 1'b1;
				wdata = acc_m | ({24'b0, md5_pkg::PAD_BYTE} << sh);
			end
			md5_pkg::BUF_ZERO: begin
				we    = (word_idx != md5_pkg::LEN_WORD_LO);
				wdata = '0;
			end
			md5_pkg::BUF_LEN_LO: begin
				we    = 1'b1;
				waddr = md5_pkg::LEN_WORD_LO;
				wdata = bits_q[31:0];
			end
			md5_pkg::BUF_LEN_HI: begin
				we    = 1'b1;
				waddr = md5_pkg::LEN_WORD_HI;
				wdata = bits_q[63:32];
			end
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		step_d = step_q;
		case (uw.jmp)
			md5_pkg::JMP_ALWAYS: step_d = uw.target;
			md5_pkg::JMP_ABSORB: begin
				if (accept) begin
					if (fill_sum[6])
						step_d = md5_pkg::ST_RUN;
					else if (s_axis_tlast)
						step_d = md5_pkg::ST_PAD;
					else
						step_d = uw.target;
				end
			end
			md5_pkg::JMP_PAD:
				step_d = (word_idx == md5_pkg::LEN_WORD_HI) ? md5_pkg::ST_RUN : uw.target;
			md5_pkg::JMP_ZERO: begin
				if (word_idx == md5_pkg::LEN_WORD_LO)
					step_d = uw.target;
				else if (word_idx == md5_pkg::LEN_WORD_HI)
					step_d = md5_pkg::ST_RUN;
				else
					step_d = md5_pkg::ST_ZERO;
			end
			md5_pkg::JMP_ROUND:
				step_d = (rnd_q == md5_pkg::LAST_ROUND) ? uw.target : md5_pkg::ST_RUN;
			md5_pkg::JMP_FINAL: begin
				if (len_q)
					step_d = md5_pkg::ST_OUT;
				else if (pad_q)
					step_d = md5_pkg::ST_ZERO;
				else if (last_q)
					step_d = md5_pkg::ST_PAD;
				else
					step_d = uw.target;
			end
			md5_pkg::JMP_OUT: step_d = out_free ? uw.target : md5_pkg::ST_OUT;
			default: step_d = md5_pkg::ST_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= md5_pkg::ST_WAIT;
			fill_q      <= '0;
			bits_q      <= '0;
			rnd_q       <= '0;
			last_q      <= 1'b0;
			pad_q       <= 1'b0;
			len_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (uw.core_op == md5_pkg::CORE_ROUND)
				rnd_q <= rnd_q + 6'd1;
			case (uw.buf_op)
				md5_pkg::BUF_ABSORB: begin
					if (accept) begin
						fill_q <= fill_sum[5:0];
						bits_q <= bits_q + {58'b0, n, 3'b000};
						last_q <= s_axis_tlast;
					end
				end
				md5_pkg::BUF_PAD: begin
					fill_q <= {word_idx + 4'd1, 2'b00};
					pad_q  <= 1'b1;
				end
				md5_pkg::BUF_ZERO: begin
					if (word_idx != md5_pkg::LEN_WORD_LO)
						fill_q <= fill_q + 6'd4;
				end
				md5_pkg::BUF_LEN_HI: len_q <= 1'b1;
				default: begin
				end
			endcase
			if (load_out) begin
				fill_q <= '0;
				bits_q <= '0;
				last_q <= 1'b0;
				pad_q  <= 1'b0;
				len_q  <= 1'b0;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			buf_q[waddr] <= wdata;
		if (accept)
			acc_q <= lane_sum[2] ? merged[63:32] : merged[31:0];
		if (load_out)
			out_data_q <= digest;
	end

	always_comb begin
		core_ctl.rnd = rnd_q;
		if (uw.core_op == md5_pkg::CORE_IV && !out_free)
			core_ctl.op = md5_pkg::CORE_HOLD;
		else
			core_ctl.op = uw.core_op;
	end

	md5_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.msg    (buf_q[md5_pkg::msg_index(rnd_q)]),
		.digest (digest)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// File: bench/tb_md5_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams directed and random messages into the engine and keeps a bit-exact
// MD5 model of its own: each accepted transfer updates the model, and each
// digest transfer is checked field by field against the oldest predicted
// digest. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_md5_message_digest;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS  = 550;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hefcdab89;
	localparam logic [31:0] H2_INIT = 32'h98badcfe;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [7:0]  PAD_MARK = 8'h80;
	localparam int          LEN_POS  = 56;

	localparam logic [0:63][31:0] ROUND_K = {
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [0:15][4:0] ROUND_SHIFT = {
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  cnt;
		logic        fin;
	} xfer_t;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} digest_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [39:0]   s_axis_tdata = '0;  // message_word[31:0], byte_count[34:32]
	logic          s_axis_tlast = 1'b0;  // last
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [127:0]  m_axis_tdata;  // digest_low[63:0], digest_high[127:64]

	xfer_t   transfer_q[$];
	digest_t digest_q[$];
	digest_t dg_want;

	logic [31:0] hash_h [4];
	logic [7:0]  blk_bytes [64];
	logic [63:0] msg_bits;
	int          blk_fill;

	int send_idle_pct = 23;
	int recv_idle_pct = 68;
	int err_count = 0;
	int items_sent = 0;
	int items_pushed = 0;
	int digests_seen = 0;
	int stall_cycles = 0;
	int queued;

	md5_message_digest u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void md5_restart();
		hash_h[0] = H0_INIT;
		hash_h[1] = H1_INIT;
		hash_h[2] = H2_INIT;
		hash_h[3] = H3_INIT;
		msg_bits = '0;
		blk_fill = 0;
	endfunction

	function automatic void md5_compress();
		logic [31:0] a, b, c, d, f, m, sum, tmp;
		logic [4:0]  s;
		int          i, g, rnd;
		a = hash_h[0];
		b = hash_h[1];
		c = hash_h[2];
		d = hash_h[3];
		for (i = 0; i < 64; i++) begin
			rnd = i / 16;
			case (rnd)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			m = {blk_bytes[4*g+3], blk_bytes[4*g+2], blk_bytes[4*g+1], blk_bytes[4*g]};
			s = ROUND_SHIFT[rnd*4 + i%4];
			sum = a + f + ROUND_K[i] + m;
			tmp = d;
			d = c;
			c = b;
			b = b + ((sum << s) | (sum >> (6'd32 - s)));
			a = tmp;
		end
		hash_h[0] = hash_h[0] + a;
		hash_h[1] = hash_h[1] + b;
		hash_h[2] = hash_h[2] + c;
		hash_h[3] = hash_h[3] + d;
	endfunction

	function automatic void md5_append(input logic [7:0] v);
		blk_bytes[blk_fill] = v;
		blk_fill = (blk_fill + 1) % 64;
		if (blk_fill == 0)
			md5_compress();
	endfunction

	function automatic void md5_predict_transfer(input logic [31:0] w, input logic [2:0] cnt,
	                                             input logic fin);
		int          n, k;
		logic [63:0] len;
		digest_t     dg;
		n = (cnt > 3'd4) ? 4 : int'(cnt);
		for (k = 0; k < n; k++)
			md5_append(w[8*k +: 8]);
		msg_bits = msg_bits + 64'(n * 8);
		if (fin) begin
			len = msg_bits;
			md5_append(PAD_MARK);
			while (blk_fill != LEN_POS)
				md5_append(8'h00);
			for (k = 0; k < 8; k++)
				md5_append(len[8*k +: 8]);
			dg.lo = {hash_h[1], hash_h[0]};
			dg.hi = {hash_h[3], hash_h[2]};
			digest_q.push_back(dg);
			md5_restart();
		end
	endfunction

	task automatic queue_transfer(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
		transfer_q.push_back('{word: w, cnt: cnt, fin: fin});
		queued++;
		items_pushed++;
	endtask

	task automatic queue_message();
		int n, k;
		if ($urandom_range(19) == 0)
			n = $urandom_range(80, 36);
		else if ($urandom_range(3) == 0)
			n = $urandom_range(17, 13);
		else
			n = $urandom_range(35, 0);
		for (k = 0; k < n; k++)
			queue_transfer($urandom(), ($urandom_range(5) == 0) ? 3'($urandom_range(7)) : 3'd4,
			               1'b0);
		queue_transfer($urandom(), 3'($urandom_range(7)), 1'b1);
	endtask

	task automatic wait_idle();
		while (items_sent != items_pushed || digest_q.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				md5_predict_transfer(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
				items_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (transfer_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					xfer_t it;
					it = transfer_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {5'b0, it.cnt, it.word};
					s_axis_tlast  <= it.fin;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and digest check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest transfer %h", m_axis_tdata);
					err_count++;
				end else begin
					dg_want = digest_q.pop_front();
					if (m_axis_tdata[63:0] !== dg_want.lo) begin
						$error("digest_low: expected %h, got %h", dg_want.lo, m_axis_tdata[63:0]);
						err_count++;
					end
					if (m_axis_tdata[127:64] !== dg_want.hi) begin
						$error("digest_high: expected %h, got %h", dg_want.hi,
						       m_axis_tdata[127:64]);
						err_count++;
					end
					digests_seen++;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int phase, k;
		md5_restart();
		queued = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		queue_transfer(32'h0, 3'd0, 1'b1);
		queue_transfer(32'hff636261, 3'd3, 1'b1);
		queue_transfer(32'hffffffff, 3'd7, 1'b1);
		queue_transfer(32'h00000000, 3'd5, 1'b0);
		queue_transfer(32'ha5a5a5a5, 3'd6, 1'b0);
		queue_transfer(32'h5a5a5a5a, 3'd4, 1'b1);
		queue_transfer(32'hdeadbeef, 3'd0, 1'b0);
		queue_transfer(32'h123456c3, 3'd1, 1'b1);
		for (k = 0; k < 14; k++)
			queue_transfer(32'h03020100 + 32'(k) * 32'h04040404, 3'd4, k == 13);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			queued = 0;
			while (queued < PHASE_ITEMS)
				queue_message();
			// hold off the next phase until every transfer is sent and every digest has arrived
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d transfers and checked %0d digests", items_sent, digests_seen);
		$display("Covered empty, padded-across-block, saturated-count and random messages");
		if (err_count == 0 && digest_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
